[rtl/one_shot_timer_queue_core_defines.svh]
// Assertion macros shared by the timer queue RTL.
// Clocked on i_clk; the gated form is disabled while i_rst_n is low.
`ifndef ONE_SHOT_TIMER_QUEUE_CORE_DEFINES_SVH
`define ONE_SHOT_TIMER_QUEUE_CORE_DEFINES_SVH

// Check a property at every clock edge once out of reset.
`define OTQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define OTQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/otq_pkg.sv]
// Package for the one-shot timer queue: sequencer states, operation and
// result codes, register index and the compare unit result type. No dependencies.
`timescale 1ns / 1ps

package otq_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_SCAN,
        ST_SCAN_END,
        ST_RESOLVE
    } t_state;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCEL    = 3'd2;
    localparam logic [2:0] KIND_EXPIRY    = 3'd3;
    localparam logic [2:0] KIND_TICK_DONE = 3'd4;

    // word index of paused_mode, taken from paddr[2]
    localparam logic CFG_IDX_PAUSED = 1'b0;

    typedef struct packed {
        logic reached;   // candidate deadline at or before now
        logic earlier;   // candidate goes ahead of the current best
    } t_cmp_res;

endpackage

[rtl/one_shot_timer_queue_core.sv]
// Top level of the one-shot timer queue: sequencer, slot store and APB register.
// Depends on otq_pkg, otq_order_cmp and one_shot_timer_queue_core_defines.svh.
`timescale 1ns / 1ps
//
// Usage: raise start with an operation word while busy is low; the word is
// taken at that edge. Tick adds elapsed_ms to program time (1 in paused_mode,
// nothing when elapsed_ms is zero), then frees every slot whose deadline is
// reached, earliest deadline first, reporting active ones as expiry results and
// closing with a tick-done result. Add stores a timer in the lowest free slot.
// Results appear on o_strobe for one cycle each, in order, o_last on the final one.
// The receiver cannot stall, so results are never held back.
// Cancel clears a slot's active mark without leaving idle, so busy never rises.
// Add scans the valid marks one slot a cycle from slot 0 until a free slot or
// the last one. A tick runs rounds of a slot scan through the store's single
// read port and the shared compare unit, one round per freed slot plus one.
// The next word can be taken at the edge that takes the final result.
// Reset (synchronous, i_rst_n low) clears time, all slot marks and paused_mode;
// the deadline/start store needs no clearing.
// Config: paused_mode at byte address 0; write only while busy is low.

module one_shot_timer_queue_core #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [30:0] i_delay_ms,
    input  logic [15:0] i_elapsed_ms,
    input  logic [3:0]  i_timer_id,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_result_id,
    output logic        o_ok,
    output logic [47:0] o_program_time,
    output logic        o_last
);
    import otq_pkg::*;

    `include "one_shot_timer_queue_core_defines.svh"

    localparam int            IW   = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [SLOTS-1:0]     r_valid, n_valid;
    logic [SLOTS-1:0]     r_active, n_active;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_have, n_have;
    logic                 r_paused;
    logic                 r_out_stb, n_out_stb;
    logic                 r_rd_pend;

    logic [30:0]          r_delay, n_delay;
    logic [IW-1:0]        r_best, n_best;
    logic [TIME_BITS-1:0] r_best_dl, n_best_dl;
    logic [TIME_BITS-1:0] r_best_st, n_best_st;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_rd_valid;
    logic [TIME_BITS-1:0] r_rd_dl, r_rd_st;
    logic [2:0]           r_kind, n_kind;
    logic [3:0]           r_id, n_id;
    logic                 r_ok, n_ok;
    logic                 r_last, n_last;
    logic [47:0]          r_out_time;

    logic [TIME_BITS-1:0] r_mem_dl [SLOTS];
    logic [TIME_BITS-1:0] r_mem_st [SLOTS];

    logic                 accept;
    logic                 cfg_wr;
    logic [TIME_BITS-1:0] add_b;
    logic [TIME_BITS-1:0] sum;
    logic [63:0]          now_ext;
    logic                 mem_we;
    logic                 eval;
    logic                 cancel_ok;
    logic [IW-1:0]        cancel_idx;
    t_cmp_res             cmp;

    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == CFG_IDX_PAUSED) ? {31'd0, r_paused} : 32'd0;
    assign now_ext = 64'(r_now);

    // one adder serves both the time advance and the deadline
    assign add_b = (r_state == ST_IDLE)
                 ? (r_paused ? TIME_BITS'(1) : TIME_BITS'(i_elapsed_ms))
                 : TIME_BITS'(r_delay);
    assign sum   = r_now + add_b;

    assign cancel_idx = IW'(i_timer_id);
    assign cancel_ok  = (32'(i_timer_id) < 32'(SLOTS)) && r_valid[cancel_idx];

    otq_order_cmp #(
        .TIME_BITS(TIME_BITS)
    ) u_cmp (
        .i_cand_dl(r_rd_dl),
        .i_cand_st(r_rd_st),
        .i_best_dl(r_best_dl),
        .i_best_st(r_best_st),
        .i_now    (r_now),
        .o_res    (cmp)
    );

    // a read issued last cycle in the scan is evaluated now
    assign eval = (r_state == ST_SCAN && r_rd_pend) || (r_state == ST_SCAN_END);

    always_comb begin
        n_state   = r_state;
        n_now     = r_now;
        n_valid   = r_valid;
        n_active  = r_active;
        n_idx     = r_idx;
        n_have    = r_have;
        n_delay   = r_delay;
        n_best    = r_best;
        n_best_dl = r_best_dl;
        n_best_st = r_best_st;
        n_out_stb = 1'b0;
        n_kind    = r_kind;
        n_id      = r_id;
        n_ok      = r_ok;
        n_last    = r_last;
        mem_we    = 1'b0;

        // strict improvement only, so the lower slot keeps a full tie
        if (eval && r_rd_valid && cmp.reached && (!r_have || cmp.earlier)) begin
            n_have    = 1'b1;
            n_best    = r_rd_idx;
            n_best_dl = r_rd_dl;
            n_best_st = r_rd_st;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_TICK: begin
                            if (i_elapsed_ms != 16'd0) begin
                                n_now = sum;
                            end
                            n_idx   = '0;
                            n_have  = 1'b0;
                            n_state = ST_SCAN;
                        end
                        OP_ADD: begin
                            n_delay = i_delay_ms;
                            n_idx   = '0;
                            n_state = ST_ADD_SCAN;
                        end
                        OP_CANCEL: begin
                            if (cancel_ok) begin
                                n_active[cancel_idx] = 1'b0;
                            end
                            n_out_stb = 1'b1;
                            n_kind    = KIND_CANCEL;
                            n_id      = i_timer_id;
                            n_ok      = cancel_ok;
                            n_last    = 1'b1;
                        end
                        default: begin
                            // unused operation: drop the word
                        end
                    endcase
                end
            end
            ST_ADD_SCAN: begin
                if (!r_valid[r_idx]) begin
                    mem_we          = 1'b1;
                    n_valid[r_idx]  = 1'b1;
                    n_active[r_idx] = 1'b1;
                    n_out_stb       = 1'b1;
                    n_kind          = KIND_ADDED;
                    n_id            = 4'(r_idx);
                    n_ok            = 1'b1;
                    n_last          = 1'b1;
                    n_state         = ST_IDLE;
                end else if (r_idx == LAST) begin
                    n_out_stb = 1'b1;
                    n_kind    = KIND_FULL;
                    n_id      = 4'd0;
                    n_ok      = 1'b0;
                    n_last    = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST) begin
                    n_state = ST_SCAN_END;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_SCAN_END: begin
                n_state = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (r_have) begin
                    if (r_active[r_best]) begin
                        n_out_stb = 1'b1;
                        n_kind    = KIND_EXPIRY;
                        n_id      = 4'(r_best);
                        n_ok      = 1'b1;
                        n_last    = 1'b0;
                    end
                    // free the slot and start the next round
                    n_valid[r_best]  = 1'b0;
                    n_active[r_best] = 1'b0;
                    n_have           = 1'b0;
                    n_idx            = '0;
                    n_state          = ST_SCAN;
                end else begin
                    n_out_stb = 1'b1;
                    n_kind    = KIND_TICK_DONE;
                    n_id      = 4'd0;
                    n_ok      = 1'b0;
                    n_last    = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_now     <= '0;
            r_valid   <= '0;
            r_active  <= '0;
            r_idx     <= '0;
            r_have    <= 1'b0;
            r_paused  <= 1'b0;
            r_out_stb <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_valid   <= n_valid;
            r_active  <= n_active;
            r_idx     <= n_idx;
            r_have    <= n_have;
            r_out_stb <= n_out_stb;
            r_rd_pend <= (r_state == ST_SCAN);
            if (cfg_wr && paddr[2] == CFG_IDX_PAUSED) begin
                r_paused <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_delay    <= n_delay;
        r_best     <= n_best;
        r_best_dl  <= n_best_dl;
        r_best_st  <= n_best_st;
        r_rd_idx   <= r_idx;
        r_rd_valid <= r_valid[r_idx];
        r_kind     <= n_kind;
        r_id       <= n_id;
        r_ok       <= n_ok;
        r_last     <= n_last;
        if (n_out_stb) begin
            r_out_time <= now_ext[47:0];
        end
    end

    // deadline and start store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_dl[r_idx] <= sum;
            r_mem_st[r_idx] <= r_now;
        end
        r_rd_dl <= r_mem_dl[r_idx];
        r_rd_st <= r_mem_st[r_idx];
    end

    assign o_strobe       = r_out_stb;
    assign o_kind         = r_kind;
    assign o_result_id    = r_id;
    assign o_ok           = r_ok;
    assign o_program_time = r_out_time;
    assign o_last         = r_last;

    `OTQ_ASSERT(a_nonlast_is_expiry, o_strobe && !o_last |-> o_kind == KIND_EXPIRY, "mid expiry")
    `OTQ_ASSERT(a_tick_goes_busy, accept && i_operation == OP_TICK |=> busy, "tick not busy")
    `OTQ_ASSERT(a_best_is_valid, r_have |-> r_valid[r_best], "chosen slot is not valid")
    `OTQ_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !busy && !o_strobe, "not quiet after reset")

endmodule

[rtl/otq_order_cmp.sv]
// Shared compare unit of the timer queue: deadline reached test and
// expiry order between a candidate slot and the best one so far. Uses otq_pkg.
`timescale 1ns / 1ps

module otq_order_cmp #(
    parameter int TIME_BITS = 48
) (
    input  logic [TIME_BITS-1:0] i_cand_dl,
    input  logic [TIME_BITS-1:0] i_cand_st,
    input  logic [TIME_BITS-1:0] i_best_dl,
    input  logic [TIME_BITS-1:0] i_best_st,
    input  logic [TIME_BITS-1:0] i_now,
    output otq_pkg::t_cmp_res    o_res
);
    import otq_pkg::*;

    always_comb begin
        o_res.reached = (i_cand_dl <= i_now);
        // earlier deadline wins; on a tie the later start goes first
        if (i_cand_dl != i_best_dl) begin
            o_res.earlier = (i_cand_dl < i_best_dl);
        end else begin
            o_res.earlier = (i_cand_st > i_best_st);
        end
    end

endmodule

[bench/one_shot_timer_queue_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for one_shot_timer_queue_core: directed and random timer commands
// in three paused_mode phases, every result word checked against a local timer model.
// Depends on otq_pkg and the timer queue RTL.

module one_shot_timer_queue_core_test;
    import otq_pkg::*;

    localparam int         SLOTS         = 16;
    localparam logic [1:0] OP_NONE       = 2'd3;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [30:0] delay;
        logic [15:0] elapsed;
        logic [3:0]  id;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  id;
        logic        ok;
        logic [47:0] ptime;
        logic        last;
    } t_timer_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start          = 1'b0;
    logic        busy;
    logic [1:0]  i_operation    = OP_TICK;
    logic [30:0] i_delay_ms     = '0;
    logic [15:0] i_elapsed_ms   = '0;
    logic [3:0]  i_timer_id     = '0;
    logic        o_strobe;
    logic [2:0]  o_kind;
    logic [3:0]  o_result_id;
    logic        o_ok;
    logic [47:0] o_program_time;
    logic        o_last;

    // timer model state
    logic [47:0] now_ms;
    logic        slot_used  [SLOTS];
    logic        slot_armed [SLOTS];
    logic [47:0] slot_begin [SLOTS];
    logic [47:0] slot_due   [SLOTS];
    logic        paused_cfg;

    t_timer_result expected_q[$];
    t_cmd          cmd_backlog[$];
    t_cmd          cmd_on_port;

    int idle_pct      = 0;
    int cmds_queued   = 0;
    int cmds_taken    = 0;
    int mismatches    = 0;
    int adds_seen     = 0;
    int full_seen     = 0;
    int cancels_seen  = 0;
    int ticks_seen    = 0;
    int expiries_seen = 0;

    one_shot_timer_queue_core #(
        .SLOTS    (SLOTS),
        .TIME_BITS(48)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_delay_ms    (i_delay_ms),
        .i_elapsed_ms  (i_elapsed_ms),
        .i_timer_id    (i_timer_id),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_result_id   (o_result_id),
        .o_ok          (o_ok),
        .o_program_time(o_program_time),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // earliest deadline first, then later start, then lower slot
    function automatic logic goes_first(int a, int b);
        if (slot_due[a] != slot_due[b]) return slot_due[a] < slot_due[b];
        if (slot_begin[a] != slot_begin[b]) return slot_begin[a] > slot_begin[b];
        return a < b;
    endfunction

    function automatic void note_result(logic [2:0] kind, int id, logic ok, logic last);
        t_timer_result r;
        r.kind  = kind;
        r.id    = 4'(id);
        r.ok    = ok;
        r.ptime = now_ms;
        r.last  = last;
        expected_q.push_back(r);
    endfunction

    function automatic void apply_timer_cmd(t_cmd c);
        int   pick;
        int   i;
        logic hit;
        case (c.op)
            OP_ADD: begin
                pick = -1;
                for (i = 0; i < SLOTS; i++)
                    if (pick < 0 && !slot_used[i]) pick = i;
                if (pick < 0) begin
                    note_result(KIND_FULL, 0, 1'b0, 1'b1);
                end else begin
                    slot_used[pick]  = 1'b1;
                    slot_armed[pick] = 1'b1;
                    slot_begin[pick] = now_ms;
                    slot_due[pick]   = now_ms + {17'd0, c.delay};
                    note_result(KIND_ADDED, pick, 1'b1, 1'b1);
                end
            end
            OP_CANCEL: begin
                hit = slot_used[c.id];
                if (hit) slot_armed[c.id] = 1'b0;
                note_result(KIND_CANCEL, c.id, hit, 1'b1);
            end
            OP_TICK: begin
                if (c.elapsed != 0)
                    now_ms = now_ms + (paused_cfg ? 48'd1 : {32'd0, c.elapsed});
                // free reached slots one at a time in expiry order
                do begin
                    pick = -1;
                    for (i = 0; i < SLOTS; i++)
                        if (slot_used[i] && slot_due[i] <= now_ms)
                            if (pick < 0 || goes_first(i, pick)) pick = i;
                    if (pick >= 0) begin
                        if (slot_armed[pick]) note_result(KIND_EXPIRY, pick, 1'b1, 1'b0);
                        slot_used[pick]  = 1'b0;
                        slot_armed[pick] = 1'b0;
                    end
                end while (pick >= 0);
                note_result(KIND_TICK_DONE, 0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_cmd(logic [1:0] op, logic [30:0] delay,
                                      logic [15:0] elapsed, logic [3:0] id);
        t_cmd c;
        c.op      = op;
        c.delay   = delay;
        c.elapsed = elapsed;
        c.id      = id;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endfunction

    // keep most deadlines reachable; full-range delays pin a slot for the rest of the run
    function automatic logic [30:0] pick_delay();
        int k;
        k = $urandom_range(99);
        if (k == 0) return 31'($urandom());
        if (paused_cfg) return (k < 90) ? 31'($urandom_range(6)) : 31'($urandom_range(40));
        if (k < 60) return 31'($urandom_range(64));
        if (k < 85) return 31'($urandom_range(4000));
        return 31'($urandom_range(1 << 18));
    endfunction

    function automatic logic [15:0] pick_elapsed();
        int k;
        k = $urandom_range(99);
        if (k < 10) return 16'd0;
        if (k < 75) return 16'($urandom_range(64, 1));
        if (k < 93) return 16'($urandom());
        return 16'hFFFF;
    endfunction

    function automatic logic [3:0] pick_slot();
        return ($urandom_range(3) != 0) ? 4'($urandom_range(5)) : 4'($urandom());
    endfunction

    task automatic queue_random(input int budget);
        int base;
        int n;
        int k;
        base = cmds_queued;
        while (cmds_queued - base < budget) begin
            k = $urandom_range(99);
            if (k < 8) begin
                queue_cmd(2'($urandom_range(3)), pick_delay(), pick_elapsed(), 4'($urandom()));
            end else if (k < 14) begin
                // burst of up to 17 adds, enough to run the store full
                n = $urandom_range(17, 12);
                repeat (n) queue_cmd(OP_ADD, pick_delay(), 16'($urandom()), 4'($urandom()));
                queue_cmd(OP_TICK, 31'($urandom()), pick_elapsed(), 4'($urandom()));
            end else begin
                n = $urandom_range(5, 1);
                repeat (n) begin
                    queue_cmd(OP_ADD, pick_delay(), 16'($urandom()), 4'($urandom()));
                    if ($urandom_range(3) == 0)
                        queue_cmd(OP_CANCEL, 31'($urandom()), 16'($urandom()), pick_slot());
                end
                repeat ($urandom_range(3, 1))
                    queue_cmd(OP_TICK, 31'($urandom()), pick_elapsed(), 4'($urandom()));
            end
        end
    endtask

    task automatic write_paused(input logic value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {CFG_IDX_PAUSED, 2'b00};
        pwdata  <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paused_cfg = value;
    endtask

    // hold until every word is taken and every result is back, then let the block go quiet
    task automatic settle();
        int waited;
        waited = 0;
        while ((cmds_taken != cmds_queued || expected_q.size() != 0 || busy)
               && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_q.size() != 0 || cmds_taken != cmds_queued) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %0d results never arrived, %0d words not taken",
                         $time, expected_q.size(), cmds_queued - cmds_taken);
            expected_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_timer_cmd(cmd_on_port);
                cmds_taken++;
            end
            if (!start || !busy) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cmd_on_port = cmd_backlog.pop_front();
                    start        <= 1'b1;
                    i_operation  <= cmd_on_port.op;
                    i_delay_ms   <= cmd_on_port.delay;
                    i_elapsed_ms <= cmd_on_port.elapsed;
                    i_timer_id   <= cmd_on_port.id;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_timer_result seen;
        t_timer_result want;
        if (i_rst_n && o_strobe) begin
            seen = {o_kind, o_result_id, o_ok, o_program_time, o_last};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word kind %0d id %0d ok %0d time %0d last %0d",
                             $time, seen.kind, seen.id, seen.ok, seen.ptime, seen.last);
            end else begin
                want = expected_q.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: expected kind %0d id %0d ok %0d time %0d last %0d,",
                                  " got kind %0d id %0d ok %0d time %0d last %0d"},
                                 $time, want.kind, want.id, want.ok, want.ptime, want.last,
                                 seen.kind, seen.id, seen.ok, seen.ptime, seen.last);
                end
                case (want.kind)
                    KIND_ADDED:     adds_seen++;
                    KIND_FULL:      full_seen++;
                    KIND_CANCEL:    cancels_seen++;
                    KIND_EXPIRY:    expiries_seen++;
                    KIND_TICK_DONE: ticks_seen++;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        int i;
        now_ms     = '0;
        paused_cfg = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_armed[i] = 1'b0;
            slot_begin[i] = '0;
            slot_due[i]   = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_paused(1'b0);
        idle_pct = 0;
        queue_cmd(OP_TICK, 31'($urandom()), 16'd0, 4'($urandom()));
        queue_cmd(OP_NONE, 31'($urandom()), 16'($urandom()), 4'($urandom()));
        queue_cmd(OP_ADD, 31'd0, 16'hFFFF, 4'hF);
        queue_cmd(OP_ADD, 31'h7FFF_FFFF, 16'd0, 4'd0);
        queue_cmd(OP_CANCEL, 31'd0, 16'd0, 4'd1);
        queue_cmd(OP_CANCEL, 31'h7FFF_FFFF, 16'hFFFF, 4'd1);
        // zero elapsed still frees the zero-delay timer
        queue_cmd(OP_TICK, 31'd0, 16'd0, 4'd0);
        queue_cmd(OP_CANCEL, 31'd0, 16'd0, 4'd0);
        queue_cmd(OP_CANCEL, 31'd0, 16'd0, 4'd15);
        // equal deadlines: later start first, then lower slot
        queue_cmd(OP_ADD, 31'd5, 16'd0, 4'd0);
        queue_cmd(OP_TICK, 31'd0, 16'd3, 4'd0);
        queue_cmd(OP_ADD, 31'd2, 16'd0, 4'd0);
        queue_cmd(OP_ADD, 31'd2, 16'd0, 4'd0);
        queue_cmd(OP_TICK, 31'd0, 16'hFFFF, 4'd0);
        // run the store full, then free the short timers
        repeat (16) queue_cmd(OP_ADD, 31'($urandom_range(40)), 16'd0, 4'd0);
        queue_cmd(OP_TICK, 31'd0, 16'd64, 4'd0);
        queue_random(128);
        settle();

        write_paused(1'b1);
        idle_pct = 79;
        queue_random(128);
        settle();

        write_paused(1'b0);
        idle_pct = 19;
        queue_random(128);
        settle();

        $display("covered %0d words over paused_mode 0/1/0 with sender gaps of 0/79/19 percent",
                 cmds_taken);
        $display("results: %0d added, %0d refused full, %0d cancels, %0d ticks, %0d expiries",
                 adds_seen, full_seen, cancels_seen, ticks_seen, expiries_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/otq_pkg.sv
rtl/otq_order_cmp.sv
rtl/one_shot_timer_queue_core.sv
bench/one_shot_timer_queue_core_test.sv
